// ===== src/dcafs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcafs_pkg
// Shared types and constants of the dual-channel ADC filter and scaler.
// ----------------------------------------------------------------------------
package dcafs_pkg;

  // Fixed-point format of the filter state: unsigned Q10.FRAC_BITS.
  localparam int FRAC_BITS = 16;
  localparam int RAW_W     = 10;
  localparam int FILT_W    = RAW_W + FRAC_BITS;
  localparam int COEF_W    = 16;

  // Shared multiplier: FILT_W by MB_W bits, product MP_W bits.
  localparam int MB_W   = 25;
  localparam int MP_W   = FILT_W + MB_W;
  localparam int KEEP_W = FILT_W + COEF_W;
  localparam int NEWP_W = RAW_W + COEF_W;
  localparam int SUM_W  = KEEP_W + 1;

  // Temperature scaling: signed difference, then divide by 2^TC_SHIFT.
  localparam int V_W      = MP_W + 1;
  localparam int TC_SHIFT = FRAC_BITS + COEF_W;
  localparam int TEMP_W   = 20;
  localparam int MV_W     = 16;
  localparam int MVS_W    = MV_W + 2;

  localparam int THR_W  = 16;
  localparam int WARM_W = 8;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_THR    = 2'd1;
  localparam logic [1:0] REG_WARMUP = 2'd2;

  // Filter coefficients, Q0.16 (each pair sums to one), and the scaling gains.
  localparam logic [MB_W-1:0] V_KEEP  = MB_W'(62259);
  localparam logic [MB_W-1:0] V_NEW   = MB_W'(3277);
  localparam logic [MB_W-1:0] T_KEEP  = MB_W'(65405);
  localparam logic [MB_W-1:0] T_NEW   = MB_W'(131);
  localparam logic [MB_W-1:0] MV_GAIN = MB_W'(122820);
  localparam logic [MB_W-1:0] TC_GAIN = MB_W'(31563636);

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
  localparam logic [MVS_W-1:0] MV_BIAS    = MVS_W'(32300);
  localparam logic [MV_W-1:0]  MV_WARMUP  = MV_W'(12000);
  localparam logic [30:0]      TC_OFS     = 31'd1525141852;
  localparam logic [V_W-1:0]   TC_OFS_SH  = V_W'(TC_OFS) << FRAC_BITS;

  // Register reset values.
  localparam logic [RAW_W-1:0]  OFFSET_RST = RAW_W'(60);
  localparam logic [THR_W-1:0]  THR_RST    = THR_W'(10500);
  localparam logic [WARM_W-1:0] WARM_RST   = WARM_W'(32);

  // Multiplier operation codes.
  localparam logic [1:0] MOP_IDLE  = 2'd0;
  localparam logic [1:0] MOP_KEEP  = 2'd1;
  localparam logic [1:0] MOP_NEW   = 2'd2;
  localparam logic [1:0] MOP_SCALE = 2'd3;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [RAW_W-1:0]  adc_offset;
    logic [THR_W-1:0]  under_thr;
    logic [WARM_W-1:0] warmup_count;
    logic              warmup_load;
  } dcafs_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic [1:0] mul_op;
    logic       save_keep;
    logic       filt;
    logic       scale;
    logic       commit;
  } dcafs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dcafs_sts_t;

endpackage

// ===== src/dcafs_cfg.sv =====
// ----------------------------------------------------------------------------
// dcafs_cfg
// APB-style register file: ADC offset, under-voltage threshold, warm-up count.
// ----------------------------------------------------------------------------
module dcafs_cfg
  import dcafs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output dcafs_cfg_t        cfg
);

  logic [RAW_W-1:0]  offset_r;
  logic [THR_W-1:0]  thr_r;
  logic [WARM_W-1:0] warm_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      thr_r    <= THR_RST;
      warm_r   <= WARM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OFFSET: offset_r <= pwdata[RAW_W-1:0];
        REG_THR:    thr_r    <= pwdata[THR_W-1:0];
        REG_WARMUP: warm_r   <= pwdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_OFFSET: prdata = CFG_DW'(offset_r);
      REG_THR:    prdata = CFG_DW'(thr_r);
      REG_WARMUP: prdata = CFG_DW'(warm_r);
      default:    prdata = '0;
    endcase
  end

  // A warm-up count write also restarts the warm-up in the datapath.
  assign cfg.adc_offset   = offset_r;
  assign cfg.under_thr    = thr_r;
  assign cfg.warmup_count = pwdata[WARM_W-1:0];
  assign cfg.warmup_load  = wr_en && (reg_idx == REG_WARMUP);

endmodule

// ===== src/dcafs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcafs_ctrl
// Sequencer that steps one sample through the shared multiplier.
// ----------------------------------------------------------------------------
module dcafs_ctrl
  import dcafs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dcafs_sts_t sts,
  output dcafs_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULK = 3'd1;
  localparam logic [2:0] ST_MULN = 3'd2;
  localparam logic [2:0] ST_FILT = 3'd3;
  localparam logic [2:0] ST_MULS = 3'd4;
  localparam logic [2:0] ST_SCL  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Only the idle state takes a new beat.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd.load_in   = 1'b0;
    cmd.mul_op    = MOP_IDLE;
    cmd.save_keep = 1'b0;
    cmd.filt      = 1'b0;
    cmd.scale     = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MULK;
        end
      end
      ST_MULK: begin
        cmd.mul_op = MOP_KEEP;
        state_nxt  = ST_MULN;
      end
      ST_MULN: begin
        cmd.save_keep = 1'b1;
        cmd.mul_op    = MOP_NEW;
        state_nxt     = ST_FILT;
      end
      ST_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = ST_MULS;
      end
      ST_MULS: begin
        cmd.mul_op = MOP_SCALE;
        state_nxt  = ST_SCL;
      end
      ST_SCL: begin
        cmd.scale = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Wait here until the output register can take the result.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new sample is only taken when no other is in flight.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == ST_MULK))
    else $error("sample loaded outside the idle state");

  // The multiplier is used exactly in the three multiply steps.
  a_mul_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_op != MOP_IDLE) |->
      (state_r == ST_MULK || state_r == ST_MULN || state_r == ST_MULS))
    else $error("multiplier started outside a multiply step");

endmodule

// ===== src/dcafs_dp.sv =====
// ----------------------------------------------------------------------------
// dcafs_dp
// Datapath: offset removal, low-pass filters, scaling and output register.
// ----------------------------------------------------------------------------
module dcafs_dp
  import dcafs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dcafs_cfg_t        cfg,
  input  dcafs_cmd_t        cmd,
  output dcafs_sts_t        sts,
  input  logic [RAW_W-1:0]  in_raw_sample,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_measured_channel,
  output logic [MV_W-1:0]   out_voltage_mv,
  output logic              out_under_voltage,
  output logic [TEMP_W-1:0] out_temp_centi,
  output logic              out_next_channel
);

  // Persistent state.
  logic              chan_r;
  logic [FILT_W-1:0] volt_filt_r;
  logic [FILT_W-1:0] temp_filt_r;
  logic [WARM_W-1:0] warm_left_r;

  // Working registers of one sample.
  logic [RAW_W-1:0]  s_r;
  logic              warm_r;
  logic [MP_W-1:0]   prod_r;
  logic [KEEP_W-1:0] keep_r;
  logic [FILT_W-1:0] nf_r;
  logic [MVS_W-1:0]  mv_r;
  logic [V_W-1:0]    v_r;

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_chan_r;
  logic [MV_W-1:0]   out_mv_r;
  logic              out_under_r;
  logic [TEMP_W-1:0] out_temp_r;

  logic [FILT_W-1:0] mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [SUM_W-1:0]  filt_sum;
  logic [V_W-1:0]    v_adj;
  logic              under_now;
  logic [MV_W-1:0]   mv_sel;
  logic              out_take;

  assign out_take     = out_valid_r & ~out_stall;
  assign sts.out_free = ~out_valid_r | ~out_stall;

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MOP_KEEP: begin
        mul_a = chan_r ? temp_filt_r : volt_filt_r;
        mul_b = chan_r ? T_KEEP : V_KEEP;
      end
      MOP_NEW: begin
        mul_a = FILT_W'(s_r);
        mul_b = chan_r ? T_NEW : V_NEW;
      end
      MOP_SCALE: begin
        mul_a = chan_r ? nf_r : FILT_W'(nf_r[FRAC_BITS +: RAW_W]);
        mul_b = chan_r ? TC_GAIN : MV_GAIN;
      end
      default: ;
    endcase
  end

  // Filter update with rounding half up.
  assign filt_sum = {1'b0, keep_r} + {1'b0, prod_r[NEWP_W-1:0], {FRAC_BITS{1'b0}}}
                    + ROUND_HALF;

  // Sample path registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s_r    <= (in_raw_sample > cfg.adc_offset) ? in_raw_sample - cfg.adc_offset : '0;
      warm_r <= (warm_left_r != '0);
    end
    if (cmd.mul_op != MOP_IDLE) begin
      prod_r <= MP_W'(mul_a) * MP_W'(mul_b);
    end
    if (cmd.save_keep) begin
      keep_r <= prod_r[KEEP_W-1:0];
    end
    if (cmd.filt) begin
      nf_r <= filt_sum[COEF_W +: FILT_W];
    end
    if (cmd.scale) begin
      mv_r <= {2'b00, prod_r[RAW_W +: MV_W]} - MV_BIAS;
      v_r  <= {1'b0, prod_r} - TC_OFS_SH;
    end
  end

  // Final scaling: signed compare, and division truncated toward zero.
  assign under_now = $signed(mv_r) < $signed({2'b00, cfg.under_thr});
  assign mv_sel    = warm_r ? MV_WARMUP : mv_r[MV_W-1:0];
  assign v_adj     = v_r + {{TEMP_W{1'b0}}, {TC_SHIFT{v_r[V_W-1]}}};

  // Filter state, warm-up counter and channel alternation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= 1'b0;
      volt_filt_r <= '0;
      temp_filt_r <= '0;
      warm_left_r <= WARM_RST;
    end else begin
      if (cfg.warmup_load) begin
        warm_left_r <= cfg.warmup_count;
      end
      if (cmd.commit) begin
        chan_r <= ~chan_r;
        if (!chan_r) begin
          volt_filt_r <= warm_r ? {s_r, {FRAC_BITS{1'b0}}} : nf_r;
          if (warm_r && !cfg.warmup_load) begin
            warm_left_r <= warm_left_r - WARM_W'(1);
          end
        end else begin
          temp_filt_r <= warm_r ? {s_r, {FRAC_BITS{1'b0}}} : nf_r;
        end
      end
    end
  end

  // Output register: filled on commit, emptied when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_chan_r  <= chan_r;
      out_mv_r    <= chan_r ? '0 : mv_sel;
      out_under_r <= chan_r ? 1'b0 : (under_now & ~warm_r);
      out_temp_r  <= chan_r ? v_adj[TC_SHIFT +: TEMP_W] : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_measured_channel = out_chan_r;
  assign out_voltage_mv       = out_mv_r;
  assign out_under_voltage    = out_under_r;
  assign out_temp_centi       = out_temp_r;
  assign out_next_channel     = ~out_chan_r;

  // A result is never written over one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result written over a stalled beat");

  // Every committed sample switches the channel.
  a_chan_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (chan_r != $past(chan_r)))
    else $error("channel did not alternate");

  // A voltage sample in warm-up uses up one warm-up count.
  a_warm_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !chan_r && warm_r && !cfg.warmup_load) |=>
      (warm_left_r == $past(warm_left_r) - WARM_W'(1)))
    else $error("warm-up count not decremented");

  // The output stays empty until a result is committed.
  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !cmd.commit) |=> !out_valid_r)
    else $error("beat presented without a committed result");

endmodule

// ===== src/dual_channel_adc_filter_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// dual_channel_adc_filter_scaler_unit
// Sequence: a sample beat is taken in idle, then steps through MULK, MULN,
// FILT, MULS, SCL and OUT; a new beat is taken only back in idle, as the
// three products go through the single shared multiplier. OUT waits while the output is stalled.
// Reset: synchronous, active low; filters cleared, voltage channel first,
// warm-up count reloaded, registers at their reset values.
// ----------------------------------------------------------------------------
module dual_channel_adc_filter_scaler_unit
  import dcafs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAW_W-1:0]  in_raw_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_measured_channel,
  output logic [MV_W-1:0]   out_voltage_mv,
  output logic              out_under_voltage,
  output logic [TEMP_W-1:0] out_temp_centi,
  output logic              out_next_channel
);

  dcafs_cfg_t cfg;
  dcafs_cmd_t cmd;
  dcafs_sts_t sts;

  // Register file.
  dcafs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  dcafs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and output register.
  dcafs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_raw_sample        (in_raw_sample),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_measured_channel (out_measured_channel),
    .out_voltage_mv       (out_voltage_mv),
    .out_under_voltage    (out_under_voltage),
    .out_temp_centi       (out_temp_centi),
    .out_next_channel     (out_next_channel)
  );

endmodule

// ===== test/dual_channel_adc_filter_scaler_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_channel_adc_filter_scaler_unit_tb
// Drives alternating voltage and temperature samples into the filter and
// scaler, and predicts every result from its own model of the filters,
// the warm-up and the scaling. The run covers several register settings,
// extremes among them, with random gaps on the input and random stalls on
// the output.
// ----------------------------------------------------------------------------
module dual_channel_adc_filter_scaler_unit_tb
  import dcafs_pkg::*;
();

  // Arithmetic of the filters and the scaling.
  localparam longint unsigned VOLT_KEEP   = 62259;
  localparam longint unsigned VOLT_ADD    = 3277;
  localparam longint unsigned TEMP_KEEP   = 65405;
  localparam longint unsigned TEMP_ADD    = 131;
  localparam int              COEF_SHIFT  = 16;
  localparam longint unsigned ROUND_ADD   = 32768;
  localparam longint unsigned MV_SCALE    = 122820;
  localparam longint signed   MV_OFFSET   = 32300;
  localparam logic [MV_W-1:0] MV_SEEDING  = 16'd12000;
  localparam longint unsigned CENTI_SCALE = 31563636;
  localparam longint unsigned CENTI_BIAS  = 1525141852;

  // Run control.
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int DRAIN_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 600000;

  typedef struct packed {
    logic              ch;
    logic [MV_W-1:0]   mv;
    logic              uv;
    logic [TEMP_W-1:0] temp_c;
    logic              nxt;
  } reading_t;

  // Scoreboard: predicts each reading from a sample beat and checks results.
  class reading_scoreboard;
    reading_t          expected_readings[$];
    logic [RAW_W-1:0]  offset_cnt;
    logic [THR_W-1:0]  threshold_mv;
    logic [WARM_W-1:0] warmup_left;
    logic              chan;
    longint unsigned   volt_q;
    longint unsigned   temp_q;
    int                errors;
    int                checked;

    function new();
      offset_cnt   = OFFSET_RST;
      threshold_mv = THR_RST;
      warmup_left  = WARM_RST;
      chan         = 1'b0;
      volt_q       = 0;
      temp_q       = 0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_OFFSET: offset_cnt   = val[RAW_W-1:0];
        REG_THR:    threshold_mv = val[THR_W-1:0];
        // Writing the warm-up length restarts the warm-up.
        REG_WARMUP: warmup_left  = val[WARM_W-1:0];
        default: ;
      endcase
    endfunction

    // First-order low-pass with Q0.16 coefficients, rounding half up.
    function longint unsigned smooth(longint unsigned f, longint unsigned s,
                                     longint unsigned keep, longint unsigned add);
      return (f * keep + (s << FRAC_BITS) * add + ROUND_ADD) >> COEF_SHIFT;
    endfunction

    function void predict_reading(logic [RAW_W-1:0] raw);
      longint unsigned s;
      longint unsigned nf;
      longint unsigned ipart;
      longint unsigned w;
      longint signed   mv;
      longint signed   thr;
      longint signed   v;
      longint signed   t;
      reading_t        r;
      s   = (raw > offset_cnt) ? longint'(raw - offset_cnt) : 0;
      thr = longint'(threshold_mv);
      r   = '0;
      r.ch = chan;
      if (chan == 1'b0) begin
        // Supply voltage: filter, scale to millivolts with 16-bit wrap.
        nf    = smooth(volt_q, s, VOLT_KEEP, VOLT_ADD);
        ipart = (nf >> FRAC_BITS) & 64'h3FF;
        w     = ((ipart * MV_SCALE) >> 10) & 64'hFFFF;
        mv    = longint'(w) - MV_OFFSET;
        volt_q = nf;
        r.mv  = mv[MV_W-1:0];
        r.uv  = (mv < thr);
        // During warm-up the filter is seeded and a fixed level reported.
        if (warmup_left != 0) begin
          warmup_left = warmup_left - 1'b1;
          volt_q = s << FRAC_BITS;
          r.mv   = MV_SEEDING;
          r.uv   = 1'b0;
        end
        chan = 1'b1;
      end else begin
        // Die temperature: filter, scale, truncate toward zero.
        nf = smooth(temp_q, s, TEMP_KEEP, TEMP_ADD);
        v  = longint'(nf * CENTI_SCALE) - longint'(CENTI_BIAS << FRAC_BITS);
        if (v < 0) begin
          t = -((-v) >>> (FRAC_BITS + COEF_SHIFT));
        end else begin
          t = v >>> (FRAC_BITS + COEF_SHIFT);
        end
        temp_q   = nf;
        r.temp_c = t[TEMP_W-1:0];
        if (warmup_left != 0) begin
          temp_q = s << FRAC_BITS;
        end
        chan = 1'b0;
      end
      r.nxt = chan;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(logic ch, logic [MV_W-1:0] mv, logic uv,
                                logic [TEMP_W-1:0] temp_c, logic nxt);
      reading_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $error("result beat with no sample waiting");
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      if (ch !== want.ch) begin
        errors++;
        $error("measured_channel: expected %0d, got %0d", want.ch, ch);
      end
      if (mv !== want.mv) begin
        errors++;
        $error("voltage_mv: expected %0d, got %0d", want.mv, mv);
      end
      if (uv !== want.uv) begin
        errors++;
        $error("under_voltage: expected %0d, got %0d", want.uv, uv);
      end
      if (temp_c !== want.temp_c) begin
        errors++;
        $error("temp_centi: expected %0d, got %0d",
               $signed(want.temp_c), $signed(temp_c));
      end
      if (nxt !== want.nxt) begin
        errors++;
        $error("next_channel: expected %0d, got %0d", want.nxt, nxt);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [RAW_W-1:0]  in_raw_sample;
  logic              out_valid;
  logic              out_stall;
  logic              out_measured_channel;
  logic [MV_W-1:0]   out_voltage_mv;
  logic              out_under_voltage;
  logic [TEMP_W-1:0] out_temp_centi;
  logic              out_next_channel;

  reading_scoreboard sb = new();
  int                cycle_cnt;
  int                settings_cnt;
  int                samples_cnt;

  dual_channel_adc_filter_scaler_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_raw_sample        (in_raw_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_measured_channel (out_measured_channel),
    .out_voltage_mv       (out_voltage_mv),
    .out_under_voltage    (out_under_voltage),
    .out_temp_centi       (out_temp_centi),
    .out_next_channel     (out_next_channel)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard limit on the run.
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output stall: short bursts of either level, with long quiet stretches
  // and the odd long stall.
  initial begin
    int hold;
    int pick;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall = 1'b0;
          hold = $urandom_range(0, 7);
        end else if (pick < 85) begin
          out_stall = 1'b1;
          hold = $urandom_range(0, 2);
        end else if (pick < 95) begin
          out_stall = 1'b0;
          hold = $urandom_range(20, 80);
        end else begin
          out_stall = 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // Result monitor: every accepted result beat is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_reading(out_measured_channel, out_voltage_mv, out_under_voltage,
                       out_temp_centi, out_next_channel);
    end
  end

  // Offers one sample beat, waits for its acceptance, then drops in_valid and
  // idles if gap is nonzero. Entered and left just after a falling edge.
  task automatic feed_sample(input logic [RAW_W-1:0] raw, input int gap);
    in_valid      = 1'b1;
    in_raw_sample = raw;
    do @(posedge clk); while (in_stall);
    sb.predict_reading(raw);
    samples_cnt++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Writes one register through the setup and access cycles.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
  endtask

  // Stops the input and waits until every expected result has come out.
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DW-1:0] ofs,
                                input logic [CFG_DW-1:0] thr,
                                input logic [CFG_DW-1:0] warm);
    drain_results();
    write_reg(REG_OFFSET, ofs);
    write_reg(REG_THR, thr);
    write_reg(REG_WARMUP, warm);
    settings_cnt++;
  endtask

  // Stimulus.
  initial begin
    logic [RAW_W-1:0]  raw;
    logic [CFG_DW-1:0] ofs;
    logic [CFG_DW-1:0] thr;
    logic [CFG_DW-1:0] warm;
    int                n;
    int                k;
    int                seg_len;
    int                pick;
    int                lvl;
    int                volt_lvl;
    int                temp_lvl;
    int                gap;
    bit                calm;
    bit                parity;

    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_raw_sample = '0;
    settings_cnt  = 0;
    samples_cnt   = 0;
    parity        = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset settings, so all of these fall in the warm-up, with
    // samples below, at and above the offset and at both extremes.
    feed_sample(10'd0, 0);
    feed_sample(10'd1023, 0);
    feed_sample(10'd59, 1);
    feed_sample(10'd60, 0);
    feed_sample(10'd61, 2);
    feed_sample(10'd1023, 0);
    feed_sample(10'd0, 0);
    feed_sample(10'd512, 0);
    feed_sample(10'd1023, 3);
    feed_sample(10'd1023, 0);
    feed_sample(10'd300, 0);
    feed_sample(10'd0, 0);

    // Directed: a warm-up of one voltage sample, then filtered readings
    // pulled towards both extremes (under-voltage, negative temperature).
    apply_settings(32'd0, 32'd10500, 32'd1);
    feed_sample(10'd1023, 0);
    feed_sample(10'd0, 0);
    for (k = 0; k < 10; k++) begin
      feed_sample((k % 2 == 0) ? 10'd0 : 10'd1023, k % 3);
    end
    parity = 1'b0;

    // Random phases, the first ones at the extremes of the registers.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin ofs = 32'd0;    thr = 32'd0;     warm = 32'd0;   end
        1: begin ofs = 32'd1023; thr = 32'd65535; warm = 32'd255; end
        2: begin ofs = 32'd0;    thr = 32'd65535; warm = 32'd2;   end
        3: begin ofs = 32'd30;   thr = 32'd12000; warm = 32'd8;   end
        default: begin
          ofs  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 120);
          thr  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 25000);
          warm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 6);
        end
      endcase
      apply_settings(ofs, thr, warm);

      // Segments hold a level per channel, so the filters settle near it.
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        seg_len  = $urandom_range(8, 60);
        volt_lvl = $urandom_range(0, 1023);
        temp_lvl = $urandom_range(0, 1023);
        calm     = ($urandom_range(0, 3) == 0);
        for (k = 0; k < seg_len && n < ITEMS_PER_PHASE; k++) begin
          lvl  = parity ? temp_lvl : volt_lvl;
          pick = $urandom_range(0, 99);
          if (pick < 80) begin
            lvl = lvl + $urandom_range(0, 16) - 8;
            if (lvl < 0) lvl = 0;
            if (lvl > 1023) lvl = 1023;
            raw = RAW_W'(lvl);
          end else if (pick < 90) begin
            raw = RAW_W'($urandom_range(0, 1023));
          end else begin
            raw = pick[0] ? 10'd1023 : 10'd0;
          end
          pick = $urandom_range(0, 99);
          if (calm || pick < 60) begin
            gap = 0;
          end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
          end else begin
            gap = $urandom_range(10, 30);
          end
          feed_sample(raw, gap);
          parity = ~parity;
          n++;
        end
      end
    end

    drain_results();

    $display("Run covered %0d sample beats and %0d checked results under %0d settings.",
             samples_cnt, sb.checked, settings_cnt + 1);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dcafs_pkg.sv
src/dcafs_cfg.sv
src/dcafs_ctrl.sv
src/dcafs_dp.sv
src/dual_channel_adc_filter_scaler_unit.sv
test/dual_channel_adc_filter_scaler_unit_tb.sv
